### design/tpd_pkg.sv
// shared types and codes for the touchpad packet decoder
package tpd_pkg;

   localparam int MAX_FINGERS_DEFAULT = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [3:0] MOTION_WEIGHT_RESET = 4'd5;

   // packet type, byte 3 bits 2:0
   localparam logic [2:0] PKT_STATUS = 3'd0;
   localparam logic [2:0] PKT_HEAD   = 3'd1;
   localparam logic [2:0] PKT_MOTION = 3'd2;
   localparam logic [2:0] PKT_CONFIG = 3'd3;

   // command codes carried through the queue
   localparam logic [1:0] CMD_STATUS = 2'd0;
   localparam logic [1:0] CMD_HEAD   = 2'd1;
   localparam logic [1:0] CMD_MOTION = 2'd2;
   localparam logic [1:0] CMD_CONFIG = 2'd3;

   // result event kinds
   localparam logic [2:0] EV_RELEASE    = 3'd0;
   localparam logic [2:0] EV_FRAME_END  = 3'd1;
   localparam logic [2:0] EV_TOUCH_ABS  = 3'd2;
   localparam logic [2:0] EV_MOTION     = 3'd3;
   localparam logic [2:0] EV_CONFIGURED = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [7:0] b4;
      logic [7:0] b5;
      logic [2:0] finger_count;
      logic       head_slot_ok;
      logic       part_a_active;
      logic       part_b_active;
   } cmd_entry_type;

endpackage

### design/tpd_front.sv
// packet classifier: drops inert packets, precomputes counts and slot checks
module tpd_front import tpd_pkg::*; #(
   parameter int MAX_FINGERS = MAX_FINGERS_DEFAULT
) (
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_packet_byte_0,
   input  logic [7:0]    req_packet_byte_1,
   input  logic [7:0]    req_packet_byte_2,
   input  logic [7:0]    req_packet_byte_3,
   input  logic [7:0]    req_packet_byte_4,
   input  logic [7:0]    req_packet_byte_5,
   input  logic          queue_full,
   output logic          push,
   output cmd_entry_type push_entry
);

   localparam logic [3:0] SLOT_LIMIT = 4'(MAX_FINGERS);

   logic [2:0] pkt_type;
   logic       keep;
   logic [3:0] count_wide;
   logic       slot_a_ok;
   logic       slot_b_ok;

   assign pkt_type  = req_packet_byte_3[2:0];
   assign slot_a_ok = {1'b0, req_packet_byte_0[7:5]} < SLOT_LIMIT;
   assign slot_b_ok = {1'b0, req_packet_byte_3[7:5]} < SLOT_LIMIT;

   always_comb begin
      count_wide = '0;
      for (int i = 0; i < MAX_FINGERS; i++) begin
         count_wide = count_wide + {3'b000, req_packet_byte_1[i]};
      end
   end

   always_comb begin
      case (pkt_type)
         PKT_STATUS, PKT_HEAD, PKT_MOTION: keep = 1'b1;
         PKT_CONFIG:                       keep = req_packet_byte_3[3];
         default:                          keep = 1'b0;
      endcase
   end

   always_comb begin
      push_entry.cmd           = pkt_type[1:0];
      push_entry.b0            = req_packet_byte_0;
      push_entry.b1            = req_packet_byte_1;
      push_entry.b2            = req_packet_byte_2;
      push_entry.b3            = req_packet_byte_3;
      push_entry.b4            = req_packet_byte_4;
      push_entry.b5            = req_packet_byte_5;
      push_entry.finger_count  = count_wide[2:0];
      push_entry.head_slot_ok  = slot_b_ok;
      push_entry.part_a_active = slot_a_ok &&
                                 ((req_packet_byte_1 != 8'd0) || (req_packet_byte_2 != 8'd0));
      push_entry.part_b_active = slot_b_ok &&
                                 ((req_packet_byte_4 != 8'd0) || (req_packet_byte_5 != 8'd0));
   end

   // inert packets are taken and dropped here
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full && keep;

endmodule

### design/tpd_queue.sv
// small command queue between classifier and executor
module tpd_queue import tpd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_entry_type push_entry,
   output logic          full,
   output logic          head_valid,
   output cmd_entry_type head_entry,
   input  logic          pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_entry_type    store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/tpd_back.sv
// command executor: finger state, omit rule and the result register
module tpd_back import tpd_pkg::*; #(
   parameter int MAX_FINGERS = MAX_FINGERS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  cmd_entry_type head_entry,
   output logic          pop,
   input  logic [3:0]    motion_weight,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_event_kind,
   output logic [2:0]    rsp_slot,
   output logic [15:0]   rsp_pos_x,
   output logic [15:0]   rsp_pos_y,
   output logic [7:0]    rsp_pressure,
   output logic [3:0]    rsp_tool_width,
   output logic [7:0]    rsp_resolution_x,
   output logic [7:0]    rsp_resolution_y,
   output logic          rsp_last
);

   localparam int IDX_W  = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
   localparam int STEP_W = $clog2(MAX_FINGERS + 1);
   localparam logic [STEP_W-1:0] STEP_FRAME_END = STEP_W'(MAX_FINGERS);

   logic [15:0]       pos_x_ff [MAX_FINGERS];
   logic [15:0]       pos_x_in [MAX_FINGERS];
   logic [15:0]       pos_y_ff [MAX_FINGERS];
   logic [15:0]       pos_y_in [MAX_FINGERS];
   logic [2:0]        prev_count_ff, prev_count_in;
   logic              skip_ff, skip_in;
   logic              pad_ready_ff, pad_ready_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              emit;
   logic [2:0]        kind_in;
   logic [2:0]        slot_in;
   logic [15:0]       x_in;
   logic [15:0]       y_in;
   logic [7:0]        pres_in;
   logic [3:0]        width_in;
   logic [7:0]        res_x_in;
   logic [7:0]        res_y_in;
   logic              last_in;

   logic [2:0]        kind_ff;
   logic [2:0]        slot_ff;
   logic [15:0]       x_ff;
   logic [15:0]       y_ff;
   logic [7:0]        pres_ff;
   logic [3:0]        width_ff;
   logic [7:0]        res_x_ff;
   logic [7:0]        res_y_ff;
   logic              last_ff;

   logic              out_free;
   logic              go;
   logic              part_b;
   logic [2:0]        mot_slot;
   logic [IDX_W-1:0]  mot_idx;
   logic [IDX_W-1:0]  head_idx;
   logic [7:0]        delta_x;
   logic [7:0]        delta_y;
   logic [3:0]        weight;
   logic signed [12:0] prod_x;
   logic signed [12:0] prod_y;
   logic [15:0]       mot_x;
   logic [15:0]       mot_y;
   logic              mask_bit;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign go       = head_valid && out_free;

   // motion part select and weighted delta
   assign part_b   = step_ff[0];
   assign mot_slot = part_b ? head_entry.b3[7:5] : head_entry.b0[7:5];
   assign mot_idx  = mot_slot[IDX_W-1:0];
   assign head_idx = head_entry.b3[IDX_W+4:5];
   assign delta_x  = part_b ? head_entry.b4 : head_entry.b1;
   assign delta_y  = part_b ? head_entry.b5 : head_entry.b2;
   assign weight   = head_entry.b0[4] ? motion_weight : 4'd1;
   assign prod_x   = $signed(delta_x) * $signed({1'b0, weight});
   assign prod_y   = $signed(delta_y) * $signed({1'b0, weight});
   assign mot_x    = pos_x_ff[mot_idx] + 16'(prod_x);
   assign mot_y    = pos_y_ff[mot_idx] + 16'(prod_y);
   assign mask_bit = head_entry.b1[3'(step_ff)];

   always_comb begin
      pop           = 1'b0;
      emit          = 1'b0;
      step_in       = step_ff;
      prev_count_in = prev_count_ff;
      skip_in       = skip_ff;
      pad_ready_in  = pad_ready_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      kind_in       = EV_RELEASE;
      slot_in       = '0;
      x_in          = '0;
      y_in          = '0;
      pres_in       = '0;
      width_in      = '0;
      res_x_in      = '0;
      res_y_in      = '0;
      last_in       = 1'b0;

      if (go) begin
         case (head_entry.cmd)
            CMD_CONFIG: begin
               emit         = 1'b1;
               kind_in      = EV_CONFIGURED;
               x_in         = {4'b0000, head_entry.b5[7:4], head_entry.b2};
               y_in         = {4'b0000, head_entry.b5[3:0], head_entry.b4};
               res_x_in     = head_entry.b0;
               res_y_in     = head_entry.b1;
               last_in      = 1'b1;
               pad_ready_in = 1'b1;
               pop          = 1'b1;
            end
            CMD_STATUS: begin
               if (!pad_ready_ff) begin
                  pop = 1'b1;
               end else if (step_ff == STEP_FRAME_END) begin
                  emit    = 1'b1;
                  kind_in = EV_FRAME_END;
                  slot_in = head_entry.finger_count;
                  last_in = 1'b1;
                  if (head_entry.finger_count < prev_count_ff) begin
                     skip_in = 1'b1;
                     if (head_entry.finger_count == 3'd0) begin
                        prev_count_in = '0;
                     end
                  end else begin
                     skip_in       = 1'b0;
                     prev_count_in = head_entry.finger_count;
                  end
                  step_in = '0;
                  pop     = 1'b1;
               end else begin
                  emit    = !mask_bit;
                  kind_in = EV_RELEASE;
                  slot_in = 3'(step_ff);
                  step_in = step_ff + 1'b1;
               end
            end
            CMD_HEAD: begin
               if (pad_ready_ff && !skip_ff && head_entry.head_slot_ok) begin
                  pos_x_in[head_idx] = {4'b0000, head_entry.b1[3:0], head_entry.b2};
                  pos_y_in[head_idx] = {4'b0000, head_entry.b4[3:0], head_entry.b5};
                  emit     = 1'b1;
                  kind_in  = EV_TOUCH_ABS;
                  slot_in  = head_entry.b3[7:5];
                  x_in     = {4'b0000, head_entry.b1[3:0], head_entry.b2};
                  y_in     = {4'b0000, head_entry.b4[3:0], head_entry.b5};
                  pres_in  = {head_entry.b1[7:4], head_entry.b4[7:4]};
                  width_in = head_entry.b0[7:4];
                  last_in  = 1'b1;
               end
               pop = 1'b1;
            end
            default: begin
               // motion: first part then second part, one per cycle while the result register is free
               if (!pad_ready_ff || skip_ff) begin
                  pop = 1'b1;
               end else begin
                  if (part_b ? head_entry.part_b_active : head_entry.part_a_active) begin
                     pos_x_in[mot_idx] = mot_x;
                     pos_y_in[mot_idx] = mot_y;
                     emit    = 1'b1;
                     kind_in = EV_MOTION;
                     slot_in = mot_slot;
                     x_in    = mot_x;
                     y_in    = mot_y;
                     last_in = part_b || !head_entry.part_b_active;
                  end
                  if (!part_b && head_entry.part_b_active) begin
                     step_in = STEP_W'(1);
                  end else begin
                     step_in = '0;
                     pop     = 1'b1;
                  end
               end
            end
         endcase
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FINGERS; i++) begin
            pos_x_ff[i] <= '0;
            pos_y_ff[i] <= '0;
         end
         prev_count_ff <= '0;
         skip_ff       <= 1'b0;
         pad_ready_ff  <= 1'b0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         prev_count_ff <= prev_count_in;
         skip_ff       <= skip_in;
         pad_ready_ff  <= pad_ready_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= kind_in;
         slot_ff  <= slot_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         pres_ff  <= pres_in;
         width_ff <= width_in;
         res_x_ff <= res_x_in;
         res_y_ff <= res_y_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_pos_x        = x_ff;
   assign rsp_pos_y        = y_ff;
   assign rsp_pressure     = pres_ff;
   assign rsp_tool_width   = width_ff;
   assign rsp_resolution_x = res_x_ff;
   assign rsp_resolution_y = res_y_ff;
   assign rsp_last         = last_ff;

endmodule

### design/touchpad_v4_packet_decoder.sv
// top level of the six-byte touchpad packet decoder
// path: an accepted packet word is queued, then the executor writes each result word into the output
//   register; silent status steps and idle first motion parts take an executor step but emit nothing
// throughput: one result word per cycle while the output register is free; status steps each finger
//   slot then frame end, motion each active part; queue takes one a cycle while not full
// reset: synchronous, clears finger positions, omit rule, pad ready flag and queue, weight 5
module touchpad_v4_packet_decoder import tpd_pkg::*; #(
   parameter int MAX_FINGERS = MAX_FINGERS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // configuration word: motion weight
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_motion_weight,
   // packet words
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_packet_byte_0,
   input  logic [7:0]         req_packet_byte_1,
   input  logic [7:0]         req_packet_byte_2,
   input  logic [7:0]         req_packet_byte_3,
   input  logic [7:0]         req_packet_byte_4,
   input  logic [7:0]         req_packet_byte_5,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_event_kind,
   output logic [2:0]         rsp_slot,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [7:0]         rsp_pressure,
   output logic [3:0]         rsp_tool_width,
   output logic [7:0]         rsp_resolution_x,
   output logic [7:0]         rsp_resolution_y,
   output logic               rsp_last
);

   logic [3:0]    motion_weight_ff, motion_weight_in;
   logic          queue_full;
   logic          push;
   cmd_entry_type push_entry;
   logic          head_valid;
   cmd_entry_type head_entry;
   logic          pop;
   logic [15:0]   pos_x_raw;
   logic [15:0]   pos_y_raw;

   // weight register, always writable; change it only while the decoder is quiet, the block does not enforce this
   assign csr_ready        = 1'b1;
   assign motion_weight_in = (csr_valid && csr_ready) ? csr_motion_weight : motion_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_weight_ff <= MOTION_WEIGHT_RESET;
      end else begin
         motion_weight_ff <= motion_weight_in;
      end
   end

   // front: classify the packet, drop unknown types and unconnected config
   tpd_front #(
      .MAX_FINGERS (MAX_FINGERS)
   ) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_packet_byte_0 (req_packet_byte_0),
      .req_packet_byte_1 (req_packet_byte_1),
      .req_packet_byte_2 (req_packet_byte_2),
      .req_packet_byte_3 (req_packet_byte_3),
      .req_packet_byte_4 (req_packet_byte_4),
      .req_packet_byte_5 (req_packet_byte_5),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   // queue decouples the classifier from the executor
   tpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // back: stateful decoding, one result word per cycle into the output register while it is free
   tpd_back #(
      .MAX_FINGERS (MAX_FINGERS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .motion_weight    (motion_weight_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_slot         (rsp_slot),
      .rsp_pos_x        (pos_x_raw),
      .rsp_pos_y        (pos_y_raw),
      .rsp_pressure     (rsp_pressure),
      .rsp_tool_width   (rsp_tool_width),
      .rsp_resolution_x (rsp_resolution_x),
      .rsp_resolution_y (rsp_resolution_y),
      .rsp_last         (rsp_last)
   );

   // positions wrap at 16 bits and are shown as two's complement
   assign rsp_pos_x = $signed(pos_x_raw);
   assign rsp_pos_y = $signed(pos_y_raw);

endmodule
